// ===== rtl/dhfk_pkg.sv =====
`default_nettype none
package dhfk_pkg;

    localparam int WORD_WIDTH = 24;
    localparam int ROT_FRAC = WORD_WIDTH - 2;
    localparam int RAD_FRAC = WORD_WIDTH - 4;
    localparam int DEG_FRAC = WORD_WIDTH - 10;

    // Internal angles are Q30 radians; the widest one is about 17 rad plus sign.
    localparam int ANGLE_WIDTH = 37;
    localparam int XY_WIDTH = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_WIDTH = 5;

    localparam logic signed [ANGLE_WIDTH-1:0] PI_Q30 = 37'sd3373259426;
    localparam logic signed [ANGLE_WIDTH-1:0] TWO_PI_Q30 = 37'sd6746518852;
    localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI_Q30 = 37'sd1686629713;
    localparam logic signed [26:0] DEG2RAD_Q30 = 27'sd18740330;
    localparam logic signed [XY_WIDTH-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] link_length;
        logic signed [WORD_WIDTH-1:0] link_twist;
        logic signed [WORD_WIDTH-1:0] link_offset;
        logic signed [WORD_WIDTH-1:0] theta_offset;
        logic signed [WORD_WIDTH-1:0] joint_angle;
        logic                         last_link;
    } link_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] r00;
        logic signed [WORD_WIDTH-1:0] r01;
        logic signed [WORD_WIDTH-1:0] r02;
        logic signed [WORD_WIDTH-1:0] r10;
        logic signed [WORD_WIDTH-1:0] r11;
        logic signed [WORD_WIDTH-1:0] r12;
        logic signed [WORD_WIDTH-1:0] r20;
        logic signed [WORD_WIDTH-1:0] r21;
        logic signed [WORD_WIDTH-1:0] r22;
        logic signed [WORD_WIDTH-1:0] pos_x;
        logic signed [WORD_WIDTH-1:0] pos_y;
        logic signed [WORD_WIDTH-1:0] pos_z;
    } pose_t;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] joint_q;
        logic signed [ANGLE_WIDTH-1:0] twist_q;
        logic signed [WORD_WIDTH-1:0]  link_length;
        logic signed [WORD_WIDTH-1:0]  link_offset;
        logic                          last_link;
    } link_job_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] sin;
        logic signed [WORD_WIDTH-1:0] cos;
    } trig_t;

    function automatic logic [30:0] atan_q30(input logic [STEP_WIDTH-1:0] idx);
        case (idx)
            5'd0:  atan_q30 = 31'h3243F6A8;
            5'd1:  atan_q30 = 31'h1DAC6705;
            5'd2:  atan_q30 = 31'h0FADBAFC;
            5'd3:  atan_q30 = 31'h07F56EA6;
            5'd4:  atan_q30 = 31'h03FEAB76;
            5'd5:  atan_q30 = 31'h01FFD55B;
            5'd6:  atan_q30 = 31'h00FFFAAA;
            5'd7:  atan_q30 = 31'h007FFF55;
            5'd8:  atan_q30 = 31'h003FFFEA;
            5'd9:  atan_q30 = 31'h001FFFFD;
            5'd10: atan_q30 = 31'h000FFFFF;
            5'd11: atan_q30 = 31'h0007FFFF;
            5'd12: atan_q30 = 31'h0003FFFF;
            5'd13: atan_q30 = 31'h0001FFFF;
            5'd14: atan_q30 = 31'h0000FFFF;
            5'd15: atan_q30 = 31'h00007FFF;
            5'd16: atan_q30 = 31'h00003FFF;
            5'd17: atan_q30 = 31'h00001FFF;
            5'd18: atan_q30 = 31'h00000FFF;
            5'd19: atan_q30 = 31'h000007FF;
            5'd20: atan_q30 = 31'h000003FF;
            5'd21: atan_q30 = 31'h000001FF;
            5'd22: atan_q30 = 31'h000000FF;
            5'd23: atan_q30 = 31'h0000007F;
            5'd24: atan_q30 = 31'h0000003F;
            5'd25: atan_q30 = 31'h0000001F;
            5'd26: atan_q30 = 31'h0000000F;
            5'd27: atan_q30 = 31'h00000008;
            5'd28: atan_q30 = 31'h00000004;
            5'd29: atan_q30 = 31'h00000002;
            default: atan_q30 = 31'h0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dhfk_if.sv =====
`default_nettype none
interface dhfk_link_if;
    logic                valid;
    logic                ready;
    dhfk_pkg::link_t     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dhfk_pose_if;
    logic                valid;
    logic                ready;
    dhfk_pkg::pose_t     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dhfk_fifo.sv =====
`default_nettype none
module dhfk_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire dhfk_pkg::link_job_t push_data,
    input  wire logic                pop,
    output dhfk_pkg::link_job_t      pop_data,
    output logic                     full,
    output logic                     empty
);

    logic [1:0]          count_reg;
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    dhfk_pkg::link_job_t mem_reg [2];

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ===== rtl/dhfk_front.sv =====
`default_nettype none
module dhfk_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    dhfk_link_if.sink           link_in,
    output logic                push,
    output dhfk_pkg::link_job_t push_data,
    input  wire logic           full
);

    localparam int W = dhfk_pkg::WORD_WIDTH;
    localparam int AW = dhfk_pkg::ANGLE_WIDTH;
    localparam int PW = W + 27;
    localparam int RAD_SHIFT = 30 - dhfk_pkg::RAD_FRAC;
    localparam logic signed [PW-1:0] DEG_HALF = PW'(1) <<< (dhfk_pkg::DEG_FRAC - 1);

    logic            stage_valid_reg;
    dhfk_pkg::link_t stage_reg;
    logic            accept;

    logic signed [PW-1:0] deg_prod;
    logic signed [PW-1:0] deg_round;

    assign accept       = link_in.valid && link_in.ready;
    assign push         = stage_valid_reg && !full;
    assign link_in.ready = !stage_valid_reg || !full;

    // Degrees to Q30 radians, then the theta offset widened to Q30.
    always_comb
    begin
        deg_prod  = PW'(stage_reg.joint_angle) * PW'(dhfk_pkg::DEG2RAD_Q30);
        deg_round = (deg_prod + DEG_HALF) >>> dhfk_pkg::DEG_FRAC;
        push_data.joint_q = AW'(deg_round)
                          + (AW'(stage_reg.theta_offset) <<< RAD_SHIFT);
        push_data.twist_q = AW'(stage_reg.link_twist) <<< RAD_SHIFT;
        push_data.link_length = stage_reg.link_length;
        push_data.link_offset = stage_reg.link_offset;
        push_data.last_link   = stage_reg.last_link;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (accept)
            stage_valid_reg <= 1'b1;
        else if (push)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= link_in.data;
    end

endmodule
`default_nettype wire

// ===== rtl/dhfk_cordic.sv =====
`default_nettype none
module dhfk_cordic (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [dhfk_pkg::ANGLE_WIDTH-1:0] angle,
    output logic                                       busy,
    output dhfk_pkg::trig_t                            result
);

    localparam int W = dhfk_pkg::WORD_WIDTH;
    localparam int AW = dhfk_pkg::ANGLE_WIDTH;
    localparam int XW = dhfk_pkg::XY_WIDTH;
    localparam int SW = dhfk_pkg::STEP_WIDTH;
    localparam int RND_SHIFT = 30 - dhfk_pkg::ROT_FRAC;
    localparam logic signed [XW-1:0] RND_HALF =
        (RND_SHIFT == 0) ? XW'(0) : (XW'(1) <<< (RND_SHIFT - 1));
    localparam logic [SW-1:0] LAST_STEP = SW'(dhfk_pkg::CORDIC_STEPS - 1);

    typedef enum logic [2:0] {C_IDLE, C_MOD, C_WRAP, C_FOLD, C_ITER, C_FINISH} cstate_t;

    cstate_t              state_reg;
    logic signed [AW-1:0] z_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic                 neg_reg;
    logic [SW-1:0]        step_reg;

    logic signed [XW-1:0] dx, dy, xn, yn;
    logic signed [AW-1:0] atan_step;

    assign busy = (state_reg != C_IDLE);

    always_comb
    begin
        dx = x_reg >>> step_reg;
        dy = y_reg >>> step_reg;
        atan_step = AW'(signed'({1'b0, dhfk_pkg::atan_q30(step_reg)}));
        xn = neg_reg ? -x_reg : x_reg;
        yn = neg_reg ? -y_reg : y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            neg_reg   <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        z_reg     <= angle;
                        x_reg     <= dhfk_pkg::CORDIC_GAIN_Q30;
                        y_reg     <= '0;
                        neg_reg   <= 1'b0;
                        step_reg  <= '0;
                        state_reg <= C_MOD;
                    end
                end
                // Truncating remainder by 2*pi, one subtraction or addition a cycle.
                C_MOD:
                begin
                    if (z_reg >= dhfk_pkg::TWO_PI_Q30)
                        z_reg <= z_reg - dhfk_pkg::TWO_PI_Q30;
                    else if (z_reg <= -dhfk_pkg::TWO_PI_Q30)
                        z_reg <= z_reg + dhfk_pkg::TWO_PI_Q30;
                    else
                        state_reg <= C_WRAP;
                end
                C_WRAP:
                begin
                    if (z_reg > dhfk_pkg::PI_Q30)
                        z_reg <= z_reg - dhfk_pkg::TWO_PI_Q30;
                    else if (z_reg < -dhfk_pkg::PI_Q30)
                        z_reg <= z_reg + dhfk_pkg::TWO_PI_Q30;
                    state_reg <= C_FOLD;
                end
                C_FOLD:
                begin
                    if (z_reg > dhfk_pkg::HALF_PI_Q30)
                    begin
                        z_reg   <= z_reg - dhfk_pkg::PI_Q30;
                        neg_reg <= 1'b1;
                    end
                    else if (z_reg < -dhfk_pkg::HALF_PI_Q30)
                    begin
                        z_reg   <= z_reg + dhfk_pkg::PI_Q30;
                        neg_reg <= 1'b1;
                    end
                    state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    if (!z_reg[AW-1])
                    begin
                        x_reg <= x_reg - dy;
                        y_reg <= y_reg + dx;
                        z_reg <= z_reg - atan_step;
                    end
                    else
                    begin
                        x_reg <= x_reg + dy;
                        y_reg <= y_reg - dx;
                        z_reg <= z_reg + atan_step;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                        state_reg <= C_FINISH;
                end
                C_FINISH:
                begin
                    result.cos <= W'((xn + RND_HALF) >>> RND_SHIFT);
                    result.sin <= W'((yn + RND_HALF) >>> RND_SHIFT);
                    state_reg  <= C_IDLE;
                end
                default:
                    state_reg <= C_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dhfk_back.sv =====
`default_nettype none
module dhfk_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               empty,
    input  wire dhfk_pkg::link_job_t pop_data,
    output logic                    pop,
    dhfk_pose_if.source             pose_out
);

    localparam int W = dhfk_pkg::WORD_WIDTH;
    localparam int LW = W + 1;
    localparam int OW = W + 2;
    localparam int PRW = 2 * OW;
    localparam int ACW = W + 4;
    localparam int ROT_FRAC = dhfk_pkg::ROT_FRAC;
    localparam int POS_SHIFT = W + 1;
    localparam logic signed [PRW-1:0] ROT_HALF = PRW'(1) <<< (ROT_FRAC - 1);
    localparam logic signed [PRW-1:0] POS_HALF = PRW'(1) <<< (POS_SHIFT - 1);
    localparam logic signed [ACW-1:0] SAT_MAX = ACW'((1 << (W - 1)) - 1);
    localparam logic signed [ACW-1:0] SAT_MIN = -ACW'(1 << (W - 1));
    localparam logic signed [W-1:0] ONE_ROT = W'(1) <<< ROT_FRAC;

    typedef enum logic [2:0] {
        B_IDLE, B_START, B_TRIG, B_BUILD, B_ROT, B_POS, B_DRAIN, B_DONE
    } bstate_t;

    typedef enum logic [2:0] {
        BLD_SQ_CA, BLD_SQ_SA, BLD_CQ_CA, BLD_CQ_SA, BLD_A_CQ, BLD_A_SQ
    } build_t;

    typedef enum logic [1:0] {MK_BUILD, MK_ROT, MK_POS} mul_kind_t;

    typedef struct packed {
        logic      valid;
        mul_kind_t kind;
        build_t    bld;
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] k;
    } mul_tag_t;

    function automatic logic [3:0] flat(input logic [1:0] r, input logic [1:0] c);
        flat = {r, 2'b00} - {2'b00, r} + {2'b00, c};
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [ACW-1:0] v);
        if (v > SAT_MAX)
            sat = SAT_MAX[W-1:0];
        else if (v < SAT_MIN)
            sat = SAT_MIN[W-1:0];
        else
            sat = v[W-1:0];
    endfunction

    bstate_t              state_reg;
    build_t               bld_reg;
    logic [1:0]           i_reg, j_reg, k_reg;
    mul_tag_t             tag_reg;
    logic                 out_valid_reg;
    dhfk_pkg::pose_t      out_reg;

    logic signed [W-1:0]  rot_reg [9];
    logic signed [W-1:0]  pos_reg [3];
    logic signed [W-1:0]  nr_reg [9];
    logic signed [W-1:0]  np_reg [3];
    logic signed [LW-1:0] lr_reg [9];
    logic signed [OW-1:0] lt_reg [3];
    logic signed [PRW-1:0] prod_reg;
    logic signed [ACW-1:0] acc_reg;
    dhfk_pkg::link_job_t  job_reg;

    dhfk_pkg::trig_t      trig_q, trig_a;
    logic                 busy_q, busy_a;
    logic                 cordic_start;

    logic signed [OW-1:0]  op_a, op_b;
    logic                  issue;
    mul_tag_t              tag_next;
    logic signed [ACW-1:0] rot_term, pos_term, term, sum;
    logic                  out_free;

    dhfk_cordic u_cordic_joint (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .angle  (job_reg.joint_q),
        .busy   (busy_q),
        .result (trig_q)
    );

    dhfk_cordic u_cordic_twist (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .angle  (job_reg.twist_q),
        .busy   (busy_a),
        .result (trig_a)
    );

    assign pop          = (state_reg == B_IDLE) && !empty;
    assign cordic_start = (state_reg == B_START);
    assign out_free     = !out_valid_reg || pose_out.ready;
    assign pose_out.valid = out_valid_reg;
    assign pose_out.data  = out_reg;

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        op_a  = '0;
        op_b  = '0;
        issue = 1'b0;
        tag_next = '{valid: 1'b0, kind: MK_BUILD, bld: bld_reg,
                     i: i_reg, j: j_reg, k: k_reg};
        unique case (state_reg)
            B_BUILD:
            begin
                issue = 1'b1;
                tag_next.kind = MK_BUILD;
                unique case (bld_reg)
                    BLD_SQ_CA: begin op_a = OW'(lr_reg[3]); op_b = OW'(lr_reg[8]); end
                    BLD_SQ_SA: begin op_a = OW'(lr_reg[3]); op_b = OW'(lr_reg[7]); end
                    BLD_CQ_CA: begin op_a = OW'(lr_reg[0]); op_b = OW'(lr_reg[8]); end
                    BLD_CQ_SA: begin op_a = OW'(lr_reg[0]); op_b = OW'(lr_reg[7]); end
                    BLD_A_CQ:  begin op_a = OW'(job_reg.link_length); op_b = OW'(lr_reg[0]); end
                    BLD_A_SQ:  begin op_a = OW'(job_reg.link_length); op_b = OW'(lr_reg[3]); end
                    default:   ;
                endcase
            end
            B_ROT:
            begin
                issue = 1'b1;
                tag_next.kind = MK_ROT;
                op_a = OW'(rot_reg[flat(i_reg, k_reg)]);
                op_b = OW'(lr_reg[flat(k_reg, j_reg)]);
            end
            B_POS:
            begin
                issue = 1'b1;
                tag_next.kind = MK_POS;
                op_a = OW'(rot_reg[flat(i_reg, k_reg)]);
                op_b = lt_reg[k_reg];
            end
            default: ;
        endcase
        tag_next.valid = issue;
    end

    // Rounding of the registered product and the running sum.
    always_comb
    begin
        rot_term = ACW'((prod_reg + ROT_HALF) >>> ROT_FRAC);
        pos_term = ACW'((prod_reg + POS_HALF) >>> POS_SHIFT);
        term     = (tag_reg.kind == MK_POS) ? pos_term : rot_term;
        if (tag_reg.k != 2'd0)
            sum = acc_reg + term;
        else if (tag_reg.kind == MK_POS)
            sum = ACW'(pos_reg[tag_reg.i]) + term;
        else
            sum = term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            bld_reg       <= BLD_SQ_CA;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            tag_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < 9; n++)
                rot_reg[n] <= (n % 4 == 0) ? ONE_ROT : '0;
            for (int n = 0; n < 3; n++)
                pos_reg[n] <= '0;
        end
        else
        begin
            tag_reg <= tag_next;
            if (out_valid_reg && pose_out.ready && state_reg != B_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                    if (!empty)
                        state_reg <= B_START;
                B_START:
                    state_reg <= B_TRIG;
                B_TRIG:
                    if (!busy_q && !busy_a)
                    begin
                        bld_reg   <= BLD_SQ_CA;
                        state_reg <= B_BUILD;
                    end
                B_BUILD:
                begin
                    if (bld_reg == BLD_A_SQ)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= B_ROT;
                    end
                    else
                        bld_reg <= build_t'(bld_reg + 3'd1);
                end
                B_ROT:
                begin
                    if (k_reg == 2'd2)
                    begin
                        k_reg <= '0;
                        if (j_reg == 2'd2)
                        begin
                            j_reg <= '0;
                            if (i_reg == 2'd2)
                            begin
                                i_reg     <= '0;
                                state_reg <= B_POS;
                            end
                            else
                                i_reg <= i_reg + 2'd1;
                        end
                        else
                            j_reg <= j_reg + 2'd1;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                end
                B_POS:
                begin
                    if (k_reg == 2'd2)
                    begin
                        k_reg <= '0;
                        if (i_reg == 2'd2)
                            state_reg <= B_DRAIN;
                        else
                            i_reg <= i_reg + 2'd1;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                end
                B_DRAIN:
                    state_reg <= B_DONE;
                B_DONE:
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg <= '{r00: nr_reg[0], r01: nr_reg[1], r02: nr_reg[2],
                                     r10: nr_reg[3], r11: nr_reg[4], r12: nr_reg[5],
                                     r20: nr_reg[6], r21: nr_reg[7], r22: nr_reg[8],
                                     pos_x: np_reg[0], pos_y: np_reg[1],
                                     pos_z: np_reg[2]};
                        // The final link of a chain leaves identity behind.
                        for (int n = 0; n < 9; n++)
                            rot_reg[n] <= job_reg.last_link
                                        ? ((n % 4 == 0) ? ONE_ROT : '0) : nr_reg[n];
                        for (int n = 0; n < 3; n++)
                            pos_reg[n] <= job_reg.last_link ? '0 : np_reg[n];
                        state_reg <= B_IDLE;
                    end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= pop_data;
        if (state_reg == B_TRIG && !busy_q && !busy_a)
        begin
            lr_reg[0] <= LW'(trig_q.cos);
            lr_reg[3] <= LW'(trig_q.sin);
            lr_reg[6] <= '0;
            lr_reg[7] <= LW'(trig_a.sin);
            lr_reg[8] <= LW'(trig_a.cos);
            lt_reg[2] <= OW'(job_reg.link_offset);
        end
        if (issue)
            prod_reg <= op_a * op_b;
        if (tag_reg.valid)
        begin
            unique case (tag_reg.kind)
                MK_BUILD:
                    unique case (tag_reg.bld)
                        BLD_SQ_CA: lr_reg[1] <= LW'(-rot_term);
                        BLD_SQ_SA: lr_reg[2] <= LW'(rot_term);
                        BLD_CQ_CA: lr_reg[4] <= LW'(rot_term);
                        BLD_CQ_SA: lr_reg[5] <= LW'(-rot_term);
                        BLD_A_CQ:  lt_reg[0] <= OW'(rot_term);
                        BLD_A_SQ:  lt_reg[1] <= OW'(rot_term);
                        default:   ;
                    endcase
                MK_ROT:
                begin
                    acc_reg <= sum;
                    if (tag_reg.k == 2'd2)
                        nr_reg[flat(tag_reg.i, tag_reg.j)] <= sat(sum);
                end
                MK_POS:
                begin
                    acc_reg <= sum;
                    if (tag_reg.k == 2'd2)
                        np_reg[tag_reg.i] <= sat(sum);
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dh_forward_kinematics_chain_unit.sv =====
// From an accepted link beat to its pose beat, a link passes the front stage
// register and the two-entry queue, the two parallel CORDIC units, 42 products on
// one shared multiplier, and the commit into the output register.
// The back end works on one link at a time, through the CORDIC and then the
// multiplier sequence; a two-entry queue lets new links enter while one is in work.
// Reset: the accumulated transform returns to identity and all queues empty.
`default_nettype none
module dh_forward_kinematics_chain_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dhfk_link_if.sink   link_in,
    dhfk_pose_if.source pose_out
);

    logic                push;
    logic                pop;
    logic                full;
    logic                empty;
    dhfk_pkg::link_job_t push_data;
    dhfk_pkg::link_job_t pop_data;

    dhfk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .link_in   (link_in),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    dhfk_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    dhfk_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .pose_out (pose_out)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !pop)
        else $error("back end took two links in a row");

endmodule
`default_nettype wire
